/* sv/gaussian_blur_3x3_core_assert.svh */
// Assertion macros used by the checker file of the 3x3 Gaussian blur core.
`ifndef GAUSSIAN_BLUR_3X3_CORE_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gb3 assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GB3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gb3 assertion failed");

`endif

/* sv/gb3_pkg.sv */
// Shared types and constants of the 3x3 Gaussian blur core.
package gb3_pkg;

    // Image geometry limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);

    // Pixel and kernel arithmetic.
    localparam int PIX_W     = 8;
    localparam int SUM_W     = PIX_W + 2;
    localparam int COEF_BITS = 16;
    localparam int PROD_C_W  = COEF_BITS + PIX_W;
    localparam int PROD_S_W  = COEF_BITS + SUM_W;
    localparam int ACC_W     = COEF_BITS + 12;

    // Configuration port.
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMG_WIDTH   = 3'd0,
        REG_IMG_HEIGHT  = 3'd1,
        REG_COEF_CENTER = 3'd2,
        REG_COEF_EDGE   = 3'd3,
        REG_COEF_CORNER = 3'd4
    } t_reg_idx;

    // Input word operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // One column of the 3x3 window, oldest row first.
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    // One line store entry: the pixel two rows up and one row up.
    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_line_ent;

endpackage

/* sv/gb3_pix_if.sv */
// Stream interface that carries input pixel words.
interface gb3_pix_if;
    logic                valid;
    logic                ready;
    logic                op;
    logic [gb3_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

/* sv/gb3_res_if.sv */
// Stream interface that carries filtered result words.
interface gb3_res_if;
    logic                valid;
    logic                ready;
    logic [gb3_pkg::PIX_W-1:0] filtered;
    logic                last_of_frame;

    modport source (output valid, output filtered, output last_of_frame, input ready);
    modport sink   (input valid, input filtered, input last_of_frame, output ready);
endinterface

/* sv/gaussian_blur_3x3_core.sv */
// 3x3 Gaussian blur core: line store, window, kernel pipeline and register port.
//
// Usage: pixel words enter on i_pix (op, pixel) in raster order with valid/ready,
// one word per clock at full rate while o_res does not stall. Filtered words leave
// on o_res with last_of_frame set on the final word of the frame. The result for an image
// pixel is produced by the input word img_width+1 positions later, so after
// the image the user sends img_width+1 flush words (op = 1) to drain it.
// A word that completes a result passes stage 1, stage 2, stage 3 and the output
// register on its way to o_res. The single line store memory is read at acceptance
// and written back when stage 1 retires, with forwarding for the one-pixel-wide
// image case. The line stores are not swept: row 0 of a frame reads both entries
// as zero and row 1 reads the upper one as zero, so a new frame starts at once.
// Geometry writes on the APB port restart the frame; coefficient writes only
// change the weights. Configure when idle.
// Reset (i_rst_n low, synchronous) restores the register defaults and clears
// the counters, window and pipeline. When o_res stalls, the pipeline stages
// keep moving until they fill; input words are taken while any stage is free.
module gaussian_blur_3x3_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gb3_pkg::ADDR_W-1:0]    paddr,
    input  logic [gb3_pkg::DATA_W-1:0]    pwdata,
    output logic [gb3_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    gb3_pix_if.sink                       i_pix,
    gb3_res_if.source                     o_res
);

    // Configuration registers.
    logic [gb3_pkg::DIM_W-1:0]     r_img_width;
    logic [gb3_pkg::DIM_W-1:0]     r_img_height;
    logic [gb3_pkg::COEF_BITS-1:0] r_coef_center;
    logic [gb3_pkg::COEF_BITS-1:0] r_coef_edge;
    logic [gb3_pkg::COEF_BITS-1:0] r_coef_corner;

    // Frame position of the next word.
    logic [gb3_pkg::DIM_W-1:0] r_row;
    logic [gb3_pkg::COL_W-1:0] r_col;
    logic [gb3_pkg::DIM_W-1:0] n_row;
    logic [gb3_pkg::COL_W-1:0] n_col;

    // Line store memory and its read port.
    gb3_pkg::t_line_ent r_mem [gb3_pkg::MAX_WIDTH];
    gb3_pkg::t_line_ent r_rd_data;
    gb3_pkg::t_line_ent r_fwd_data;
    logic               r_fwd;

    // Stage 1: word waiting for its line store data.
    logic                      r_s1_valid;
    gb3_pkg::t_pix             r_s1_pix;
    logic                      r_s1_emit;
    logic                      r_s1_last;
    logic                      r_s1_c0;
    logic                      r_s1_cge2;
    logic                      r_s1_rge1;
    logic                      r_s1_rge2;
    logic [gb3_pkg::COL_W-1:0] r_s1_idx;

    // Window columns: older (col 1) and newer (col 2).
    gb3_pkg::t_col r_win_c1;
    gb3_pkg::t_col r_win_c2;

    // Stage 2: neighbor sums.
    logic                      r_s2_valid;
    logic                      r_s2_last;
    gb3_pkg::t_pix             r_s2_center;
    logic [gb3_pkg::SUM_W-1:0] r_s2_edge;
    logic [gb3_pkg::SUM_W-1:0] r_s2_corner;

    // Stage 3: weighted products.
    logic                         r_s3_valid;
    logic                         r_s3_last;
    logic [gb3_pkg::PROD_C_W-1:0] r_s3_prod_c;
    logic [gb3_pkg::PROD_S_W-1:0] r_s3_prod_e;
    logic [gb3_pkg::PROD_S_W-1:0] r_s3_prod_k;

    // Output register.
    logic          r_o_valid;
    gb3_pkg::t_pix r_o_filtered;
    logic          r_o_last;

    // Combinational signals.
    logic                      cfg_wr;
    logic                      geo_wr;
    logic [gb3_pkg::WID_W-1:0] w_eff;
    logic [gb3_pkg::DIM_W-1:0] h_eff;
    logic                      w_ge2;
    logic                      acc_in;
    gb3_pkg::t_pix             in_pix;
    logic                      in_emit;
    logic                      in_last;
    logic [gb3_pkg::WID_W:0]   col_inc;
    logic                      s1_adv;
    logic                      s2_adv;
    logic                      s3_adv;
    gb3_pkg::t_line_ent        rd_ent;
    gb3_pkg::t_pix             mem_lo;
    gb3_pkg::t_pix             mem_up;
    gb3_pkg::t_col             new_col;
    gb3_pkg::t_col             left_col;
    gb3_pkg::t_col             right_col;
    logic                      left_ok;
    logic [gb3_pkg::SUM_W-1:0] sum_edge;
    logic [gb3_pkg::SUM_W-1:0] sum_corner;
    logic [gb3_pkg::ACC_W-1:0] acc_sum;
    logic [gb3_pkg::ACC_W-gb3_pkg::COEF_BITS-1:0] acc_int;
    gb3_pkg::t_pix             sat_pix;

    // APB: always ready, write on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // A write to either geometry register restarts the frame.
    assign geo_wr = cfg_wr &&
                    ((paddr[gb3_pkg::ADDR_W-1:2] == gb3_pkg::REG_IMG_WIDTH) ||
                     (paddr[gb3_pkg::ADDR_W-1:2] == gb3_pkg::REG_IMG_HEIGHT));

    // Register read-back.
    always_comb begin
        unique case (paddr[gb3_pkg::ADDR_W-1:2])
            gb3_pkg::REG_IMG_WIDTH:   prdata = gb3_pkg::DATA_W'(r_img_width);
            gb3_pkg::REG_IMG_HEIGHT:  prdata = gb3_pkg::DATA_W'(r_img_height);
            gb3_pkg::REG_COEF_CENTER: prdata = gb3_pkg::DATA_W'(r_coef_center);
            gb3_pkg::REG_COEF_EDGE:   prdata = gb3_pkg::DATA_W'(r_coef_edge);
            gb3_pkg::REG_COEF_CORNER: prdata = gb3_pkg::DATA_W'(r_coef_corner);
            default:                  prdata = '0;
        endcase
    end

    // Effective geometry, clamped to the supported range.
    always_comb begin
        if (r_img_width == '0) begin
            w_eff = gb3_pkg::WID_W'(1);
        end else if (int'(r_img_width) > gb3_pkg::MAX_WIDTH) begin
            w_eff = gb3_pkg::WID_W'(gb3_pkg::MAX_WIDTH);
        end else begin
            w_eff = gb3_pkg::WID_W'(r_img_width);
        end
        if (r_img_height == '0) begin
            h_eff = gb3_pkg::DIM_W'(1);
        end else if (int'(r_img_height) > gb3_pkg::MAX_HEIGHT) begin
            h_eff = gb3_pkg::DIM_W'(gb3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_img_height;
        end
    end
    assign w_ge2 = (w_eff >= gb3_pkg::WID_W'(2));

    // Each stage moves when the next is free or moving, stage 1 also when it emits nothing.
    assign s3_adv = r_s3_valid && (!r_o_valid || o_res.ready);
    assign s2_adv = r_s2_valid && (!r_s3_valid || s3_adv);
    assign s1_adv = r_s1_valid && (!r_s1_emit || !r_s2_valid || s2_adv);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign acc_in = i_pix.valid && i_pix.ready;

    // Classify the incoming word by its frame position.
    always_comb begin
        in_pix = '0;
        if ((i_pix.op == gb3_pkg::OP_PIXEL) && (r_row < h_eff)) begin
            in_pix = i_pix.pixel;
        end
        in_emit = (r_row >= gb3_pkg::DIM_W'(2)) ||
                  ((r_row == gb3_pkg::DIM_W'(1)) && (r_col != '0));
        in_last = (r_row == gb3_pkg::DIM_W'(h_eff + gb3_pkg::DIM_W'(1))) && (r_col == '0);
        col_inc = (gb3_pkg::WID_W + 1)'(r_col) + (gb3_pkg::WID_W + 1)'(1);
    end

    // Next frame position; the final word of a frame restarts the count.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (in_last) begin
            n_row = '0;
            n_col = '0;
        end else if (col_inc >= {1'b0, w_eff}) begin
            n_row = r_row + gb3_pkg::DIM_W'(1);
            n_col = '0;
        end else begin
            n_col = r_col + gb3_pkg::COL_W'(1);
        end
    end

    // Line store data with forwarding; rows not yet written in this frame read zero.
    always_comb begin
        rd_ent = r_fwd ? r_fwd_data : r_rd_data;
        mem_lo = r_s1_rge1 ? rd_ent.lower : '0;
        mem_up = r_s1_rge2 ? rd_ent.upper : '0;
        new_col.top = mem_up;
        new_col.mid = mem_lo;
        new_col.bot = r_s1_pix;
    end

    // Window operands: the centre column is the newer stored column.
    always_comb begin
        left_ok   = r_s1_c0 ? w_ge2 : r_s1_cge2;
        left_col  = left_ok ? r_win_c1 : '0;
        right_col = r_s1_c0 ? '0 : new_col;
        sum_corner = gb3_pkg::SUM_W'(left_col.top) + gb3_pkg::SUM_W'(left_col.bot) +
                     gb3_pkg::SUM_W'(right_col.top) + gb3_pkg::SUM_W'(right_col.bot);
        sum_edge   = gb3_pkg::SUM_W'(r_win_c2.top) + gb3_pkg::SUM_W'(r_win_c2.bot) +
                     gb3_pkg::SUM_W'(left_col.mid) + gb3_pkg::SUM_W'(right_col.mid);
    end

    // Accumulate, round half up and saturate.
    always_comb begin
        acc_sum = gb3_pkg::ACC_W'(r_s3_prod_c) + gb3_pkg::ACC_W'(r_s3_prod_e) +
                  gb3_pkg::ACC_W'(r_s3_prod_k) +
                  gb3_pkg::ACC_W'(1 << (gb3_pkg::COEF_BITS - 1));
        acc_int = acc_sum[gb3_pkg::ACC_W-1:gb3_pkg::COEF_BITS];
        if (acc_int > (gb3_pkg::ACC_W - gb3_pkg::COEF_BITS)'(255)) begin
            sat_pix = '1;
        end else begin
            sat_pix = acc_int[gb3_pkg::PIX_W-1:0];
        end
    end

    // Line store: read at acceptance, written back when stage 1 retires.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_rd_data       <= r_mem[r_col];
            r_fwd_data.upper <= mem_lo;
            r_fwd_data.lower <= r_s1_pix;
        end
        if (s1_adv) begin
            r_mem[r_s1_idx].upper <= mem_lo;
            r_mem[r_s1_idx].lower <= r_s1_pix;
        end
    end

    // Control state, configuration, counters and window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width   <= gb3_pkg::DIM_W'(50);
            r_img_height  <= gb3_pkg::DIM_W'(50);
            r_coef_center <= gb3_pkg::COEF_BITS'(13381);
            r_coef_edge   <= gb3_pkg::COEF_BITS'(8116);
            r_coef_corner <= gb3_pkg::COEF_BITS'(4923);
            r_row         <= '0;
            r_col         <= '0;
            r_fwd         <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s3_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
            r_win_c1      <= '0;
            r_win_c2      <= '0;
        end else begin
            // Frame position and stage 1 occupancy; a geometry write restarts the count.
            if (geo_wr) begin
                r_row <= '0;
                r_col <= '0;
            end else if (acc_in) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (acc_in) begin
                r_fwd <= s1_adv && (r_s1_idx == r_col);
            end
            if (acc_in) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // Window shift; the final word of a frame or a geometry write empties it.
            if (geo_wr) begin
                r_win_c1 <= '0;
                r_win_c2 <= '0;
            end else if (s1_adv) begin
                if (r_s1_last) begin
                    r_win_c1 <= '0;
                    r_win_c2 <= '0;
                end else begin
                    r_win_c1 <= r_win_c2;
                    r_win_c2 <= new_col;
                end
            end

            // Occupancy of the arithmetic stages and the output register.
            if (s1_adv && r_s1_emit) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_valid <= 1'b1;
            end else if (s3_adv) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end

            // Register writes.
            if (cfg_wr) begin
                unique case (paddr[gb3_pkg::ADDR_W-1:2])
                    gb3_pkg::REG_IMG_WIDTH: begin
                        r_img_width <= pwdata[gb3_pkg::DIM_W-1:0];
                    end
                    gb3_pkg::REG_IMG_HEIGHT: begin
                        r_img_height <= pwdata[gb3_pkg::DIM_W-1:0];
                    end
                    gb3_pkg::REG_COEF_CENTER: begin
                        r_coef_center <= pwdata[gb3_pkg::COEF_BITS-1:0];
                    end
                    gb3_pkg::REG_COEF_EDGE: begin
                        r_coef_edge <= pwdata[gb3_pkg::COEF_BITS-1:0];
                    end
                    gb3_pkg::REG_COEF_CORNER: begin
                        r_coef_corner <= pwdata[gb3_pkg::COEF_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_pix  <= in_pix;
            r_s1_emit <= in_emit;
            r_s1_last <= in_last;
            r_s1_c0   <= (r_col == '0);
            r_s1_cge2 <= (r_col >= gb3_pkg::COL_W'(2));
            r_s1_rge1 <= (r_row >= gb3_pkg::DIM_W'(1));
            r_s1_rge2 <= (r_row >= gb3_pkg::DIM_W'(2));
            r_s1_idx  <= r_col;
        end
        if (s1_adv && r_s1_emit) begin
            r_s2_last   <= r_s1_last;
            r_s2_center <= r_win_c2.mid;
            r_s2_edge   <= sum_edge;
            r_s2_corner <= sum_corner;
        end
        if (s2_adv) begin
            r_s3_last   <= r_s2_last;
            r_s3_prod_c <= gb3_pkg::PROD_C_W'(r_coef_center) *
                           gb3_pkg::PROD_C_W'(r_s2_center);
            r_s3_prod_e <= gb3_pkg::PROD_S_W'(r_coef_edge) *
                           gb3_pkg::PROD_S_W'(r_s2_edge);
            r_s3_prod_k <= gb3_pkg::PROD_S_W'(r_coef_corner) *
                           gb3_pkg::PROD_S_W'(r_s2_corner);
        end
        if (s3_adv) begin
            r_o_filtered <= sat_pix;
            r_o_last     <= r_s3_last;
        end
    end

    // Result word outputs.
    assign o_res.valid         = r_o_valid;
    assign o_res.filtered      = r_o_filtered;
    assign o_res.last_of_frame = r_o_last;

endmodule

/* sv/gb3_checker.sv */
// Port-level checker for the 3x3 Gaussian blur core and its bind statement.
`include "gaussian_blur_3x3_core_assert.svh"

module gb3_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [gb3_pkg::PIX_W-1:0]  i_out_filtered,
    input logic                       i_out_last,
    input logic                       i_psel,
    input logic                       i_penable,
    input logic                       i_pwrite,
    input logic [gb3_pkg::ADDR_W-1:0] i_paddr,
    input logic [gb3_pkg::DATA_W-1:0] i_pwdata,
    input logic [gb3_pkg::DATA_W-1:0] i_prdata
);

    logic                       cfg_wr;
    logic [gb3_pkg::ADDR_W-1:0] addr_width;
    logic [gb3_pkg::ADDR_W-1:0] addr_center;
    logic                       wr_width;
    logic                       wr_center;
    logic                       out_stall;

    // Register addresses and write strobes seen on the port.
    assign addr_width  = {gb3_pkg::REG_IMG_WIDTH, 2'b00};
    assign addr_center = {gb3_pkg::REG_COEF_CENTER, 2'b00};
    assign cfg_wr      = i_psel && i_penable && i_pwrite;
    assign wr_width    = cfg_wr && (i_paddr == addr_width);
    assign wr_center   = cfg_wr && (i_paddr == addr_center);
    assign out_stall   = i_out_valid && !i_out_ready;

    // The input side stalls only when the output word is held back.
    `GB3_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, (!out_stall), (i_in_ready || !i_in_valid || i_in_ready))

    // A stalled result word stays in place.
    `GB3_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, (i_out_valid && $stable(i_out_filtered) && $stable(i_out_last)))

    // A written width reads back at once.
    `GB3_ASSERT_IMP(a_width_rd, i_clk, i_rst_n, ($past(wr_width) && $past(i_rst_n) && (i_paddr == addr_width)), (i_prdata[gb3_pkg::DIM_W-1:0] == $past(i_pwdata[gb3_pkg::DIM_W-1:0])))

    // A written centre weight reads back at once.
    `GB3_ASSERT_IMP(a_center_rd, i_clk, i_rst_n, ($past(wr_center) && $past(i_rst_n) && (i_paddr == addr_center)), (i_prdata[gb3_pkg::COEF_BITS-1:0] == $past(i_pwdata[gb3_pkg::COEF_BITS-1:0])))

endmodule

bind gaussian_blur_3x3_core gb3_checker u_gb3_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pix.valid),
    .i_in_ready     (i_pix.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_filtered (o_res.filtered),
    .i_out_last     (o_res.last_of_frame),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);

/* test/gaussian_blur_3x3_core_test.sv */
// Self-checking testbench of the 3x3 Gaussian blur core with stream, register and scoreboard logic.
module gaussian_blur_3x3_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Register defaults after reset.
    localparam int unsigned RESET_WIDTH  = 50;
    localparam int unsigned RESET_HEIGHT = 50;
    localparam logic [gb3_pkg::COEF_BITS-1:0] RESET_CENTER = 16'd13381;
    localparam logic [gb3_pkg::COEF_BITS-1:0] RESET_EDGE   = 16'd8116;
    localparam logic [gb3_pkg::COEF_BITS-1:0] RESET_CORNER = 16'd4923;

    // Register indexes past the end of the map; writes there must be ignored.
    localparam logic [gb3_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [gb3_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [63:0] ROUND_HALF = 64'd1 << (gb3_pkg::COEF_BITS - 1);
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_WORDS  = 250;
    localparam int unsigned QUIET_FROM    = 200;

    // One filtered word as it leaves the block.
    typedef struct packed {
        gb3_pkg::t_pix filtered;
        logic          last_of_frame;
    } t_blur_word;

    // Tracks the filter state, predicts filtered words and checks the output stream.
    class blur_tracker;
        logic [gb3_pkg::DIM_W-1:0]     width_reg;
        logic [gb3_pkg::DIM_W-1:0]     height_reg;
        logic [gb3_pkg::COEF_BITS-1:0] w_center;
        logic [gb3_pkg::COEF_BITS-1:0] w_edge;
        logic [gb3_pkg::COEF_BITS-1:0] w_corner;
        gb3_pkg::t_pix                 upper [gb3_pkg::MAX_WIDTH];
        gb3_pkg::t_pix                 lower [gb3_pkg::MAX_WIDTH];
        gb3_pkg::t_pix                 win [9];
        int unsigned                   row_pos;
        int unsigned                   col_pos;
        t_blur_word                    due_words [$];
        int unsigned                   words_in;
        int unsigned                   words_out;
        int unsigned                   frames_done;
        int unsigned                   reg_writes;
        int unsigned                   errors;

        function new();
            width_reg   = gb3_pkg::DIM_W'(RESET_WIDTH);
            height_reg  = gb3_pkg::DIM_W'(RESET_HEIGHT);
            w_center    = RESET_CENTER;
            w_edge      = RESET_EDGE;
            w_corner    = RESET_CORNER;
            words_in    = 0;
            words_out   = 0;
            frames_done = 0;
            reg_writes  = 0;
            errors      = 0;
            restart();
        endfunction

        // Start a new frame: counters, both line stores and the window go to zero.
        function void restart();
            for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
                upper[i] = '0;
                lower[i] = '0;
            end
            for (int i = 0; i < 9; i++) begin
                win[i] = '0;
            end
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < 1) return 1;
            if (width_reg > gb3_pkg::MAX_WIDTH) return gb3_pkg::MAX_WIDTH;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg < 1) return 1;
            if (height_reg > gb3_pkg::MAX_HEIGHT) return gb3_pkg::MAX_HEIGHT;
            return 32'(height_reg);
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction

        // Geometry writes restart the frame; weight writes take effect at once.
        function void write_reg(logic [gb3_pkg::REG_IDX_W-1:0] idx,
                                logic [gb3_pkg::DATA_W-1:0] value);
            reg_writes++;
            case (idx)
                gb3_pkg::REG_IMG_WIDTH: begin
                    width_reg = value[gb3_pkg::DIM_W-1:0];
                    restart();
                end
                gb3_pkg::REG_IMG_HEIGHT: begin
                    height_reg = value[gb3_pkg::DIM_W-1:0];
                    restart();
                end
                gb3_pkg::REG_COEF_CENTER: w_center = value[gb3_pkg::COEF_BITS-1:0];
                gb3_pkg::REG_COEF_EDGE:   w_edge   = value[gb3_pkg::COEF_BITS-1:0];
                gb3_pkg::REG_COEF_CORNER: w_corner = value[gb3_pkg::COEF_BITS-1:0];
                default: ;
            endcase
        endfunction

        // One window column, oldest row first, or zeros where it lies outside the image.
        function gb3_pkg::t_col column(int c, bit keep);
            gb3_pkg::t_col col;
            col = '0;
            if (keep) begin
                col.top = win[c];
                col.mid = win[3 + c];
                col.bot = win[6 + c];
            end
            return col;
        endfunction

        // Weighted kernel sum, rounded half up and saturated to 8 bits.
        function gb3_pkg::t_pix weigh(gb3_pkg::t_col l, gb3_pkg::t_col m, gb3_pkg::t_col r);
            logic [63:0] corner_sum;
            logic [63:0] edge_sum;
            logic [63:0] acc;
            logic [63:0] val;
            corner_sum = 64'(l.top) + 64'(l.bot) + 64'(r.top) + 64'(r.bot);
            edge_sum   = 64'(m.top) + 64'(m.bot) + 64'(l.mid) + 64'(r.mid);
            acc = 64'(w_center) * 64'(m.mid) + 64'(w_edge) * edge_sum
                + 64'(w_corner) * corner_sum;
            val = (acc + ROUND_HALF) >> gb3_pkg::COEF_BITS;
            return (val > 64'd255) ? 8'hFF : val[gb3_pkg::PIX_W-1:0];
        endfunction

        // Note an accepted input word and queue the filtered word it completes, if any.
        function void take_word(logic op, gb3_pkg::t_pix pixel);
            int unsigned   w;
            int unsigned   h;
            int unsigned   r;
            int unsigned   c;
            gb3_pkg::t_pix v;
            bit            emit;
            bit            at_end;
            gb3_pkg::t_pix res;
            t_blur_word    item;
            w = eff_width();
            h = eff_height();
            r = row_pos;
            c = col_pos;
            v = (op == gb3_pkg::OP_PIXEL && r < h) ? pixel : '0;
            emit = (r >= 2) || (r == 1 && c >= 1);
            at_end = (r == h + 1) && (c == 0);
            res = '0;
            words_in++;

            // At the start of a row the centre is the last pixel of the row two above.
            if (emit && c == 0) begin
                res = weigh(column(1, w >= 2), column(2, 1'b1), '0);
            end

            // Shift the window and bring in the new column from the line stores.
            for (int k = 0; k < 3; k++) begin
                win[k * 3]     = win[k * 3 + 1];
                win[k * 3 + 1] = win[k * 3 + 2];
            end
            win[2]   = upper[c];
            win[5]   = lower[c];
            win[8]   = v;
            upper[c] = lower[c];
            lower[c] = v;

            if (emit && c >= 1) begin
                res = weigh(column(0, c >= 2), column(1, 1'b1), column(2, 1'b1));
            end

            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1) & 32'h7FF;
            end else begin
                col_pos = c + 1;
            end

            if (emit) begin
                item.filtered      = res;
                item.last_of_frame = at_end;
                due_words.insert(due_words.size(), item);
                if (at_end) begin
                    frames_done++;
                    restart();
                end
            end
        endfunction

        // Compare one accepted output word with the oldest prediction.
        function void match_word(gb3_pkg::t_pix filtered, logic last_of_frame);
            t_blur_word item;
            if (due_words.size() == 0) begin
                $error("unexpected output word: filtered %0d, last_of_frame %0b",
                       filtered, last_of_frame);
                errors++;
                return;
            end
            item = due_words.pop_front();
            words_out++;
            if (filtered !== item.filtered) begin
                $error("filtered: expected %0d, actual %0d", item.filtered, filtered);
                errors++;
            end
            if (last_of_frame !== item.last_of_frame) begin
                $error("last_of_frame: expected %0b, actual %0b",
                       item.last_of_frame, last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [gb3_pkg::ADDR_W-1:0] paddr;
    logic [gb3_pkg::DATA_W-1:0] pwdata;
    logic [gb3_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       idle_on;
    logic                       live;
    logic                       hold_go;
    logic                       pressing;

    blur_tracker sb;

    gb3_pix_if pix_bus ();
    gb3_res_if res_bus ();

    gaussian_blur_3x3_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end

    // Output side: check every accepted word and stall in random bursts.
    initial begin
        int unsigned burst_left;
        burst_left = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (live === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                sb.match_word(res_bus.filtered, res_bus.last_of_frame);
            end
            if (burst_left != 0) begin
                burst_left--;
            end else if (idle_on && $urandom_range(0, 99) < 6) begin
                burst_left = $urandom_range(1, 19);
            end
            res_bus.ready <= !pressing && (burst_left == 0);
        end
    end

    // Long output hold-off, so the pipeline fills and the input stalls.
    initial begin
        pressing <= 1'b0;
        @(posedge i_clk);
        while (hold_go !== 1'b1) @(posedge i_clk);
        pressing <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        pressing <= 1'b0;
    end

    function automatic gb3_pkg::t_pix pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return gb3_pkg::t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one input word, with an occasional gap ahead of it, until accepted.
    task automatic send_word(logic op, gb3_pkg::t_pix pixel);
        if (idle_on && $urandom_range(0, 99) < 6) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.op    <= op;
        pix_bus.pixel <= pixel;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        sb.take_word(op, pixel);
    endtask

    // Stop offering words and wait until every predicted word has come out.
    task automatic drain();
        pix_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(logic [gb3_pkg::REG_IDX_W-1:0] idx,
                             logic [gb3_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Geometry write; the unused upper data bits carry random values.
    task automatic geometry(int unsigned w, int unsigned h);
        logic [gb3_pkg::DATA_W-1:0] value;
        value = $urandom;
        value[gb3_pkg::DIM_W-1:0] = w[gb3_pkg::DIM_W-1:0];
        apb_write(gb3_pkg::REG_IMG_WIDTH, value);
        value = $urandom;
        value[gb3_pkg::DIM_W-1:0] = h[gb3_pkg::DIM_W-1:0];
        apb_write(gb3_pkg::REG_IMG_HEIGHT, value);
    endtask

    task automatic coefs(logic [gb3_pkg::COEF_BITS-1:0] c, logic [gb3_pkg::COEF_BITS-1:0] e,
                         logic [gb3_pkg::COEF_BITS-1:0] k);
        logic [gb3_pkg::DATA_W-1:0] value;
        value = $urandom;
        value[gb3_pkg::COEF_BITS-1:0] = c;
        apb_write(gb3_pkg::REG_COEF_CENTER, value);
        value = $urandom;
        value[gb3_pkg::COEF_BITS-1:0] = e;
        apb_write(gb3_pkg::REG_COEF_EDGE, value);
        value = $urandom;
        value[gb3_pkg::COEF_BITS-1:0] = k;
        apb_write(gb3_pkg::REG_COEF_CORNER, value);
    endtask

    // One frame at the current geometry, followed by its flush words. A noisy frame
    // mixes in flush words inside the image, pixels after it and a wrong flush count.
    task automatic send_frame(bit noisy, inout int unsigned sent);
        int unsigned w;
        int unsigned h;
        int unsigned n_flush;
        logic        op;
        w = sb.eff_width();
        h = sb.eff_height();
        for (int unsigned i = 0; i < w * h; i++) begin
            op = (noisy && $urandom_range(0, 19) == 0) ? gb3_pkg::OP_FLUSH : gb3_pkg::OP_PIXEL;
            send_word(op, pick_pixel());
        end
        n_flush = w + 1;
        if (noisy && $urandom_range(0, 2) == 0) begin
            n_flush = $urandom_range(0, w + 3);
        end
        for (int unsigned i = 0; i < n_flush; i++) begin
            op = (noisy && $urandom_range(0, 4) == 0) ? gb3_pkg::OP_PIXEL : gb3_pkg::OP_FLUSH;
            send_word(op, pick_pixel());
        end
        sent += w * h + n_flush;
    endtask

    // New register setting between random phases; the third one carries the hold-off.
    task automatic new_setting(int unsigned phase);
        int unsigned w;
        int unsigned h;
        if (phase == 2) begin
            geometry(40, 3);
            hold_go <= 1'b1;
        end else if (phase == 0 || $urandom_range(0, 9) < 7) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 32) : $urandom_range(1, 10);
            h = $urandom_range(1, 5);
            geometry(w, h);
        end
        case ($urandom_range(0, 3))
            0: coefs(RESET_CENTER, RESET_EDGE, RESET_CORNER);
            1: coefs(gb3_pkg::COEF_BITS'($urandom_range(0, 20000)),
                     gb3_pkg::COEF_BITS'($urandom_range(0, 8000)),
                     gb3_pkg::COEF_BITS'($urandom_range(0, 4000)));
            2: coefs({gb3_pkg::COEF_BITS{$urandom_range(0, 1) == 1}},
                     {gb3_pkg::COEF_BITS{$urandom_range(0, 1) == 1}},
                     {gb3_pkg::COEF_BITS{$urandom_range(0, 1) == 1}});
            default: coefs(gb3_pkg::COEF_BITS'($urandom), gb3_pkg::COEF_BITS'($urandom),
                           gb3_pkg::COEF_BITS'($urandom));
        endcase
    endtask

    // Main sequence: reset, directed cases, geometry extremes, then random phases.
    initial begin
        int unsigned sent;
        int unsigned phase;
        sb = new();
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.op    <= gb3_pkg::OP_PIXEL;
        pix_bus.pixel <= '0;
        idle_on       <= 1'b1;
        live          <= 1'b0;
        hold_go       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        live    <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: three rows of a 50-wide frame, left unfinished.
        for (int i = 0; i < 3 * RESET_WIDTH; i++) begin
            send_word(gb3_pkg::OP_PIXEL, pick_pixel());
        end
        drain();

        // Writes past the register map change nothing.
        apb_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        apb_write(REG_SPARE_HI, 32'h0000_0000);

        // A geometry write restarts the unfinished frame; then a 3x2 frame with a
        // flush word inside the image and a pixel word past its end.
        geometry(3, 2);
        send_word(gb3_pkg::OP_PIXEL, 8'h00);
        send_word(gb3_pkg::OP_PIXEL, 8'hFF);
        send_word(gb3_pkg::OP_PIXEL, 8'hFF);
        send_word(gb3_pkg::OP_FLUSH, 8'hFF);
        send_word(gb3_pkg::OP_PIXEL, 8'hFF);
        send_word(gb3_pkg::OP_PIXEL, 8'h00);
        send_word(gb3_pkg::OP_FLUSH, 8'h00);
        send_word(gb3_pkg::OP_PIXEL, 8'hC8);
        send_word(gb3_pkg::OP_FLUSH, 8'hAA);
        send_word(gb3_pkg::OP_FLUSH, 8'h55);
        drain();

        // Largest weights saturate the output.
        coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        geometry(2, 2);
        repeat (4) send_word(gb3_pkg::OP_PIXEL, 8'hFF);
        repeat (3) send_word(gb3_pkg::OP_FLUSH, 8'h00);
        drain();

        // Zero weights, and zero geometry that acts as a single pixel.
        coefs(16'h0000, 16'h0000, 16'h0000);
        geometry(0, 0);
        send_word(gb3_pkg::OP_PIXEL, 8'hFF);
        send_word(gb3_pkg::OP_FLUSH, 8'h00);
        send_word(gb3_pkg::OP_FLUSH, 8'hFF);
        drain();

        // Geometry beyond the limits; the next geometry write restarts the partial frame.
        coefs(RESET_CENTER, RESET_EDGE, RESET_CORNER);
        geometry(2047, 2047);
        repeat (24) send_word(gb3_pkg::OP_PIXEL, pick_pixel());
        drain();

        // Random phases; the last stretch runs without gaps on either side.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS || phase < 4) begin
            if (phase >= 3 || sent >= QUIET_FROM) begin
                idle_on <= 1'b0;
            end
            new_setting(phase);
            if (phase == 2) begin
                send_frame(1'b0, sent);
            end else begin
                repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3) == 0, sent);
            end
            drain();
            phase++;
        end

        drain();
        $display("Covered %0d input words and %0d filtered words over %0d complete frames,",
                 sb.words_in, sb.words_out, sb.frames_done);
        $display("with %0d register writes, single-pixel to out-of-range geometry and a long stall.",
                 sb.reg_writes);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/gb3_pkg.sv
sv/gb3_pix_if.sv
sv/gb3_res_if.sv
sv/gaussian_blur_3x3_core.sv
sv/gb3_checker.sv
test/gaussian_blur_3x3_core_test.sv
